@@ sv/bmpdec_pkg.sv @@
// ----------------------------------------------------------------------------
// BMP pixel decoder package
// Shared widths, header byte positions, parse phase codes and the word types
// used by the decoder core and its channel interfaces.
// ----------------------------------------------------------------------------
`default_nettype none

package bmpdec_pkg;

   // Field widths
   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned DIM_W   = 13;
   localparam int unsigned INDEX_W = 24;
   localparam int unsigned POS_W   = 32;
   localparam int unsigned HPOS_W  = 5;
   localparam int unsigned BPP_W   = 5;

   // Header byte positions (little-endian fields)
   localparam logic [HPOS_W-1:0] OFFSET_POS = 5'd10;
   localparam logic [HPOS_W-1:0] WIDTH_POS  = 5'd18;
   localparam logic [HPOS_W-1:0] HEIGHT_POS = 5'd22;
   localparam logic [HPOS_W-1:0] BPP_POS    = 5'd28;
   localparam logic [HPOS_W-1:0] HDR_LAST   = 5'd29;

   // An offset at or below this position starts pixel data right after the header
   localparam logic [POS_W-1:0] PIXEL_START = 32'd30;

   // Color constants
   localparam logic [BYTE_W-1:0] BYTE_FULL    = 8'hFF;
   localparam logic [BYTE_W-1:0] BYTE_ZERO    = 8'h00;
   localparam logic [BYTE_W-1:0] ALPHA_OPAQUE = 8'hFF;
   localparam logic [BYTE_W-1:0] ALPHA_CLEAR  = 8'h00;

   // Color component order within a pixel
   localparam logic [1:0] COMP_BLUE  = 2'd0;
   localparam logic [1:0] COMP_GREEN = 2'd1;
   localparam logic [1:0] COMP_RED   = 2'd2;

   typedef enum logic [3:0] {
      PH_IDLE   = 4'b0001,
      PH_HEADER = 4'b0010,
      PH_SKIP   = 4'b0100,
      PH_PIXELS = 4'b1000
   } phase_type;

   typedef struct packed {
      phase_type            phase;
      logic [POS_W-1:0]     byte_pos;
      logic [POS_W-1:0]     data_offset;
      logic [POS_W-1:0]     raw_width;
      logic [POS_W-1:0]     raw_height;
      logic [BPP_W-1:0]     bpp_low;
      logic [DIM_W-1:0]     image_width;
      logic [DIM_W-1:0]     image_height;
      logic [DIM_W-1:0]     column;
      logic [DIM_W-1:0]     row;
      logic [1:0]           comp_phase;
      logic [1:0]           pad_remaining;
      logic [1:0]           pad_size;
      logic [BYTE_W-1:0]    held_blue;
      logic [BYTE_W-1:0]    held_green;
      logic [INDEX_W-1:0]   row_base;
   } parse_state_type;

   localparam parse_state_type STATE_CLEAR = '{phase: PH_IDLE, default: '0};

   typedef struct packed {
      logic [INDEX_W-1:0] pixel_index;
      logic [BYTE_W-1:0]  red;
      logic [BYTE_W-1:0]  green;
      logic [BYTE_W-1:0]  blue;
      logic [BYTE_W-1:0]  alpha;
      logic               last_pixel;
      logic               header_error;
   } pixel_word_type;

endpackage

`default_nettype wire

@@ sv/bmpdec_req_if.sv @@
// ----------------------------------------------------------------------------
// BMP decoder byte channel
// Valid/ready channel that carries one file byte and its start-of-file flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface bmpdec_req_if;
   logic                             valid;
   logic                             ready;
   logic [bmpdec_pkg::BYTE_W-1:0]    file_byte;
   logic                             first_byte;

   modport source (output valid, output file_byte, output first_byte, input ready);
   modport sink   (input valid, input file_byte, input first_byte, output ready);
endinterface

`default_nettype wire

@@ sv/bmpdec_rsp_if.sv @@
// ----------------------------------------------------------------------------
// BMP decoder pixel channel
// Valid/ready channel that carries one decoded RGBA pixel or a header error.
// ----------------------------------------------------------------------------
`default_nettype none

interface bmpdec_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [bmpdec_pkg::INDEX_W-1:0]    pixel_index;
   logic [bmpdec_pkg::BYTE_W-1:0]     red;
   logic [bmpdec_pkg::BYTE_W-1:0]     green;
   logic [bmpdec_pkg::BYTE_W-1:0]     blue;
   logic [bmpdec_pkg::BYTE_W-1:0]     alpha;
   logic                              last_pixel;
   logic                              header_error;

   modport source (output valid, output pixel_index, output red, output green,
                   output blue, output alpha, output last_pixel,
                   output header_error, input ready);
   modport sink   (input valid, input pixel_index, input red, input green,
                   input blue, input alpha, input last_pixel,
                   input header_error, output ready);
endinterface

`default_nettype wire

@@ sv/bmp_stream_pixel_decoder_core.sv @@
// ----------------------------------------------------------------------------
// BMP stream pixel decoder
// Parses a 24-bit BMP byte stream and emits RGBA pixels at flipped indices.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus carries one file byte per word; first_byte marks byte 0 of a file
//   and restarts the parse from any point. rsp_bus carries one pixel word per
//   red byte of pixel data, or a single word with header_error set when the
//   width or height is zero or above MAX_DIM (parsing then stops until the
//   next first_byte). last_pixel flags the final pixel; later bytes are
//   dropped until the next file starts.
//   Throughput: one byte per cycle while req_bus.ready is high. Each byte
//   passes through one layer of logic (byte counter compare, column/row
//   update, index add; the header's (height-1)*width product only on byte
//   29) into the state and the output register; the word is out next cycle.
//   The output register holds a word while rsp_bus.ready is low; req_bus.ready
//   stays high as long as that register is empty or being drained, so input
//   stalls only when a word waits and the receiver is not taking it.
//   Reset (synchronous) empties the output register and leaves the parser
//   idle, ignoring bytes until one arrives with first_byte set.
// ----------------------------------------------------------------------------
`default_nettype none

module bmp_stream_pixel_decoder_core #(
   parameter int unsigned MAX_DIM = 4096
) (
   input  wire logic        clock,
   input  wire logic        reset,
   bmpdec_req_if.sink       req_bus,
   bmpdec_rsp_if.source     rsp_bus
);
   import bmpdec_pkg::*;

   parse_state_type              state_ff;
   parse_state_type              state_in;
   parse_state_type              cur_state;
   pixel_word_type               rsp_word_ff;
   pixel_word_type               word_in;
   logic                         rsp_valid_ff;
   logic                         emit;
   logic                         req_accept;
   logic [BYTE_W-1:0]            in_byte;
   logic [POS_W-1:0]             pos_next;
   logic [HPOS_W-1:0]            hdr_pos;
   logic [HPOS_W-1:0]            offset_lane;
   logic [HPOS_W-1:0]            width_lane;
   logic [HPOS_W-1:0]            height_lane;
   logic                         dim_error;
   logic [BPP_W-1:0]             row_bits;
   logic [1:0]                   row_quot;
   logic [2*DIM_W-1:0]           base_prod;
   logic [DIM_W-1:0]             column_inc;
   logic [DIM_W-1:0]             row_inc;
   logic                         is_last;
   logic                         is_magenta;

   assign req_accept    = req_bus.valid && req_bus.ready;
   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign in_byte       = req_bus.file_byte;

   // Restart the parse on a first byte
   always_comb begin
      cur_state = state_ff;
      if (req_bus.first_byte) begin
         cur_state       = STATE_CLEAR;
         cur_state.phase = PH_HEADER;
      end
   end

   // Header field lanes and image geometry
   assign pos_next    = cur_state.byte_pos + POS_W'(1);
   assign hdr_pos     = cur_state.byte_pos[HPOS_W-1:0];
   assign offset_lane = hdr_pos - OFFSET_POS;
   assign width_lane  = hdr_pos - WIDTH_POS;
   assign height_lane = hdr_pos - HEIGHT_POS;
   assign dim_error   = (cur_state.raw_width == '0) ||
                        (cur_state.raw_width > POS_W'(MAX_DIM)) ||
                        (cur_state.raw_height == '0) ||
                        (cur_state.raw_height > POS_W'(MAX_DIM));
   // Row bits mod 32 depend on the low five bits of width and depth only
   assign row_bits    = BPP_W'(cur_state.raw_width[BPP_W-1:0] * cur_state.bpp_low);
   assign row_quot    = row_bits[BPP_W-1:BPP_W-2];
   assign base_prod   = (cur_state.raw_height[DIM_W-1:0] - DIM_W'(1)) *
                        cur_state.raw_width[DIM_W-1:0];

   // Pixel position
   assign column_inc  = cur_state.column + DIM_W'(1);
   assign row_inc     = cur_state.row + DIM_W'(1);
   assign is_last     = (row_inc == cur_state.image_height) &&
                        (column_inc == cur_state.image_width);
   assign is_magenta  = (in_byte == BYTE_FULL) && (cur_state.held_green == BYTE_ZERO) &&
                        (cur_state.held_blue == BYTE_FULL);

   // Advance the parser by one byte
   always_comb begin
      state_in = cur_state;
      emit     = 1'b0;
      word_in  = '0;
      unique case (cur_state.phase)
         PH_IDLE: begin
         end
         PH_HEADER: begin
            state_in.byte_pos = pos_next;
            if (hdr_pos >= OFFSET_POS && hdr_pos < OFFSET_POS + HPOS_W'(4)) begin
               state_in.data_offset[{offset_lane[1:0], 3'b000} +: BYTE_W] = in_byte;
            end
            if (hdr_pos >= WIDTH_POS && hdr_pos < WIDTH_POS + HPOS_W'(4)) begin
               state_in.raw_width[{width_lane[1:0], 3'b000} +: BYTE_W] = in_byte;
            end
            if (hdr_pos >= HEIGHT_POS && hdr_pos < HEIGHT_POS + HPOS_W'(4)) begin
               state_in.raw_height[{height_lane[1:0], 3'b000} +: BYTE_W] = in_byte;
            end
            if (hdr_pos == BPP_POS) begin
               state_in.bpp_low = in_byte[BPP_W-1:0];
            end
            if (hdr_pos == HDR_LAST) begin
               if (dim_error) begin
                  emit                 = 1'b1;
                  word_in.header_error = 1'b1;
                  state_in.phase       = PH_IDLE;
               end else begin
                  state_in.image_width   = cur_state.raw_width[DIM_W-1:0];
                  state_in.image_height  = cur_state.raw_height[DIM_W-1:0];
                  state_in.pad_size      = 2'(-row_quot);
                  state_in.row_base      = base_prod[INDEX_W-1:0];
                  state_in.column        = '0;
                  state_in.row           = '0;
                  state_in.comp_phase    = COMP_BLUE;
                  state_in.pad_remaining = '0;
                  state_in.phase = (cur_state.data_offset <= PIXEL_START) ? PH_PIXELS : PH_SKIP;
               end
            end
         end
         PH_SKIP: begin
            state_in.byte_pos = pos_next;
            if (pos_next == cur_state.data_offset) begin
               state_in.phase = PH_PIXELS;
            end
         end
         PH_PIXELS: begin
            state_in.byte_pos = pos_next;
            if (cur_state.pad_remaining != '0) begin
               // drop row padding
               state_in.pad_remaining = cur_state.pad_remaining - 2'd1;
            end else if (cur_state.comp_phase == COMP_BLUE) begin
               state_in.held_blue  = in_byte;
               state_in.comp_phase = COMP_GREEN;
            end else if (cur_state.comp_phase == COMP_GREEN) begin
               state_in.held_green = in_byte;
               state_in.comp_phase = COMP_RED;
            end else begin
               emit                = 1'b1;
               state_in.comp_phase = COMP_BLUE;
               word_in.pixel_index = cur_state.row_base + INDEX_W'(cur_state.column);
               word_in.red         = in_byte;
               word_in.green       = cur_state.held_green;
               word_in.blue        = cur_state.held_blue;
               word_in.alpha       = is_magenta ? ALPHA_CLEAR : ALPHA_OPAQUE;
               word_in.last_pixel  = is_last;
               state_in.column     = column_inc;
               if (column_inc >= cur_state.image_width) begin
                  state_in.column        = '0;
                  state_in.row           = row_inc;
                  state_in.row_base      = cur_state.row_base -
                                           INDEX_W'(cur_state.image_width);
                  state_in.pad_remaining = cur_state.pad_size;
               end
               if (is_last) begin
                  state_in.phase = PH_IDLE;
               end
            end
         end
         default: begin
            state_in.phase = PH_IDLE;
         end
      endcase
   end

   // Hold parser state; update on each accepted word
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_CLEAR;
      end else if (req_accept) begin
         state_ff <= state_in;
      end
   end

   // Output register: load on a result, drain when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept && emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && emit) begin
         rsp_word_ff <= word_in;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.pixel_index  = rsp_word_ff.pixel_index;
   assign rsp_bus.red          = rsp_word_ff.red;
   assign rsp_bus.green        = rsp_word_ff.green;
   assign rsp_bus.blue         = rsp_word_ff.blue;
   assign rsp_bus.alpha        = rsp_word_ff.alpha;
   assign rsp_bus.last_pixel   = rsp_word_ff.last_pixel;
   assign rsp_bus.header_error = rsp_word_ff.header_error;

endmodule

`default_nettype wire

@@ sv/bmpdec_checker.sv @@
// ----------------------------------------------------------------------------
// BMP decoder port checker
// Watches the decoder's channels and flags output words that break its rules.
// ----------------------------------------------------------------------------
`default_nettype none

module bmpdec_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                req_valid,
   input wire logic                                req_ready,
   input wire logic                                rsp_valid,
   input wire logic                                rsp_ready,
   input wire logic [bmpdec_pkg::INDEX_W-1:0]      pixel_index,
   input wire logic [bmpdec_pkg::BYTE_W-1:0]       red,
   input wire logic [bmpdec_pkg::BYTE_W-1:0]       green,
   input wire logic [bmpdec_pkg::BYTE_W-1:0]       blue,
   input wire logic [bmpdec_pkg::BYTE_W-1:0]       alpha,
   input wire logic                                last_pixel,
   input wire logic                                header_error
);
   import bmpdec_pkg::*;

   // Hold a stalled word
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(pixel_index) && $stable(red) &&
         $stable(green) && $stable(blue) && $stable(alpha) && $stable(last_pixel) &&
         $stable(header_error))
      else $error("stalled output word changed");

   // A new word only follows an accepted input word
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready))
      else $error("output word without accepted input");

   // Error words carry nothing else
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && header_error |-> pixel_index == '0 && red == BYTE_ZERO &&
         green == BYTE_ZERO && blue == BYTE_ZERO && alpha == BYTE_ZERO && !last_pixel)
      else $error("error word with nonzero fields");

   // Alpha is clear for the magenta key only
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !header_error |->
         (alpha == ALPHA_CLEAR && red == BYTE_FULL && green == BYTE_ZERO &&
          blue == BYTE_FULL) ||
         (alpha == ALPHA_OPAQUE &&
          !(red == BYTE_FULL && green == BYTE_ZERO && blue == BYTE_FULL)))
      else $error("alpha does not match color key");

endmodule

bind bmp_stream_pixel_decoder_core bmpdec_checker u_bmpdec_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_bus.valid),
   .req_ready    (req_bus.ready),
   .rsp_valid    (rsp_bus.valid),
   .rsp_ready    (rsp_bus.ready),
   .pixel_index  (rsp_bus.pixel_index),
   .red          (rsp_bus.red),
   .green        (rsp_bus.green),
   .blue         (rsp_bus.blue),
   .alpha        (rsp_bus.alpha),
   .last_pixel   (rsp_bus.last_pixel),
   .header_error (rsp_bus.header_error)
);

`default_nettype wire

@@ verif/bmp_stream_pixel_decoder_core_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BMP stream pixel decoder testbench
// Streams synthetic BMP files byte by byte into the decoder. A behavioral
// decoder in the testbench computes the expected RGBA words, and a monitor
// checks each word that the core returns against them in order. The sender
// runs in bursts and the receiver stalls. Header errors, restarts in the middle
// of a file, data offsets that skip bytes and odd row padding are all covered.
// ----------------------------------------------------------------------------
module bmp_stream_pixel_decoder_core_test;
   import bmpdec_pkg::*;

   localparam int unsigned DIM_LIMIT     = 4096;
   localparam int unsigned HEADER_BYTES  = 30;
   localparam int unsigned PLAN_BYTES    = 1950;
   localparam int unsigned CYCLE_LIMIT   = 250000;
   localparam int unsigned HOLDOFF_AT    = 800;
   localparam int unsigned HOLDOFF_LEN   = 400;
   localparam int unsigned DRAIN_CYCLES  = 16;
   localparam int unsigned NO_CUT        = 32'hFFFF_FFFF;
   localparam logic [7:0]  STALL_PATTERN = 8'b1011_0110;

   typedef struct packed {
      logic [BYTE_W-1:0] value;
      logic              opens_file;
   } file_word_type;

   logic clock;
   logic reset;

   bmpdec_req_if req_bus ();
   bmpdec_rsp_if rsp_bus ();

   bmp_stream_pixel_decoder_core #(.MAX_DIM(DIM_LIMIT)) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   file_word_type  byte_plan[$];
   pixel_word_type pending_pixels[$];
   pixel_word_type oldest_pixel;
   int             mismatch_count = 0;
   int unsigned    cycle_count = 0;

   // Decoder state kept by the testbench
   phase_type   dec_phase;
   int unsigned dec_pos;
   int unsigned dec_offset;
   int unsigned dec_raw_w;
   int unsigned dec_raw_h;
   int unsigned dec_bpp;
   int unsigned dec_w;
   int unsigned dec_h;
   int unsigned dec_col;
   int unsigned dec_row;
   int unsigned dec_comp;
   int unsigned dec_pad_left;
   int unsigned dec_pad_size;
   int unsigned dec_row_base;
   logic [7:0]  dec_blue;
   logic [7:0]  dec_green;

   // Sender and receiver pacing
   int unsigned burst_left;
   int unsigned gap_left;
   int unsigned hold_left;
   int unsigned mode_left;
   int unsigned stall_mode;
   logic        holdoff_done;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Behavioral decoder: advance the parse by one byte, queue any pixel word
   // ------------------------------------------------------------------------
   task automatic clear_decoder();
      dec_phase = PH_IDLE;
      dec_pos = 0; dec_offset = 0; dec_raw_w = 0; dec_raw_h = 0; dec_bpp = 0;
      dec_w = 0; dec_h = 0; dec_col = 0; dec_row = 0; dec_comp = COMP_BLUE;
      dec_pad_left = 0; dec_pad_size = 0; dec_row_base = 0;
      dec_blue = '0; dec_green = '0;
   endtask

   task automatic decode_byte(input logic [7:0] b, input logic opens_file);
      int unsigned    p;
      int unsigned    q;
      logic           last;
      pixel_word_type word;
      word = '0;
      if (opens_file) begin
         clear_decoder();
         dec_phase = PH_HEADER;
      end
      p = dec_pos;
      case (dec_phase)
         PH_HEADER: begin
            dec_pos = p + 1;
            if (p >= OFFSET_POS && p <= OFFSET_POS + 3)
               dec_offset |= 32'(b) << (8 * (p - OFFSET_POS));
            if (p >= WIDTH_POS && p <= WIDTH_POS + 3)
               dec_raw_w |= 32'(b) << (8 * (p - WIDTH_POS));
            if (p >= HEIGHT_POS && p <= HEIGHT_POS + 3)
               dec_raw_h |= 32'(b) << (8 * (p - HEIGHT_POS));
            if (p >= BPP_POS && p <= BPP_POS + 1)
               dec_bpp |= 32'(b) << (8 * (p - BPP_POS));
            if (p == HDR_LAST) begin
               if (dec_raw_w == 0 || dec_raw_w > DIM_LIMIT ||
                   dec_raw_h == 0 || dec_raw_h > DIM_LIMIT) begin
                  // Bad size: one error word, then wait for the next file
                  word.header_error = 1'b1;
                  pending_pixels.push_back(word);
                  dec_phase = PH_IDLE;
               end else begin
                  dec_w = dec_raw_w & 32'h1FFF;
                  dec_h = dec_raw_h & 32'h1FFF;
                  q = ((dec_w * (dec_bpp & 32'hFFFF)) & 31) / 8;
                  dec_pad_size = (q > 0) ? 4 - q : 0;
                  dec_row_base = ((dec_h - 1) * dec_w) & 32'hFF_FFFF;
                  dec_col = 0; dec_row = 0; dec_comp = COMP_BLUE; dec_pad_left = 0;
                  dec_phase = (dec_offset <= PIXEL_START) ? PH_PIXELS : PH_SKIP;
               end
            end
         end
         PH_SKIP: begin
            dec_pos = p + 1;
            if (dec_pos == dec_offset) dec_phase = PH_PIXELS;
         end
         PH_PIXELS: begin
            dec_pos = p + 1;
            if (dec_pad_left != 0) begin
               dec_pad_left--;
            end else if (dec_comp == COMP_BLUE) begin
               dec_blue = b;
               dec_comp = COMP_GREEN;
            end else if (dec_comp == COMP_GREEN) begin
               dec_green = b;
               dec_comp = COMP_RED;
            end else begin
               dec_comp = COMP_BLUE;
               last = (dec_row + 1 == dec_h) && (dec_col + 1 == dec_w);
               word.pixel_index = INDEX_W'(dec_row_base + dec_col);
               word.red         = b;
               word.green       = dec_green;
               word.blue        = dec_blue;
               word.alpha       = (b == BYTE_FULL && dec_green == BYTE_ZERO &&
                                   dec_blue == BYTE_FULL) ? ALPHA_CLEAR : ALPHA_OPAQUE;
               word.last_pixel  = last;
               pending_pixels.push_back(word);
               // Wrap to the next row up in the flipped image
               dec_col++;
               if (dec_col >= dec_w) begin
                  dec_col = 0;
                  dec_row++;
                  dec_row_base = (dec_row_base - dec_w) & 32'hFF_FFFF;
                  dec_pad_left = dec_pad_size;
               end
               if (last) dec_phase = PH_IDLE;
            end
         end
         default: ;
      endcase
   endtask

   // ------------------------------------------------------------------------
   // File builder: header, skip bytes, padded rows, trailing junk; cut short
   // after 'cut' bytes so that the next file restarts the parse
   // ------------------------------------------------------------------------
   task automatic plan_file(input int unsigned w, input int unsigned h,
                            input int unsigned off, input int unsigned bpp,
                            input int unsigned cut);
      logic [7:0]  body[$];
      logic [7:0]  px[3];
      logic [7:0]  val;
      int unsigned q;
      int unsigned pad;
      int unsigned kind;
      int unsigned n;
      n = 0;
      for (int i = 0; i < HEADER_BYTES; i++) begin
         val = 8'($urandom_range(0, 255));
         if (i >= OFFSET_POS && i <= OFFSET_POS + 3) val = 8'(off >> (8 * (i - OFFSET_POS)));
         if (i >= WIDTH_POS && i <= WIDTH_POS + 3)   val = 8'(w >> (8 * (i - WIDTH_POS)));
         if (i >= HEIGHT_POS && i <= HEIGHT_POS + 3) val = 8'(h >> (8 * (i - HEIGHT_POS)));
         if (i >= BPP_POS && i <= BPP_POS + 1)       val = 8'(bpp >> (8 * (i - BPP_POS)));
         body.push_back(val);
      end
      if (w >= 1 && w <= DIM_LIMIT && h >= 1 && h <= DIM_LIMIT) begin
         q = ((w * (bpp & 32'hFFFF)) & 31) / 8;
         pad = (q > 0) ? 4 - q : 0;
         for (int unsigned s = HEADER_BYTES; s < off && body.size() < cut; s++)
            body.push_back(8'($urandom_range(0, 255)));
         for (int unsigned r = 0; r < h && body.size() < cut; r++) begin
            for (int unsigned c = 0; c < w && body.size() < cut; c++) begin
               // First pixel of every file is the magenta key
               kind = (n == 0) ? 0 : $urandom_range(0, 7);
               px[0] = BYTE_FULL; px[1] = BYTE_ZERO; px[2] = BYTE_FULL;
               if (kind == 2)
                  px[$urandom_range(0, 2)] ^= 8'(1 << $urandom_range(0, 7));
               else if (kind > 2)
                  foreach (px[k]) px[k] = 8'($urandom_range(0, 255));
               foreach (px[k]) body.push_back(px[k]);
               n++;
            end
            for (int unsigned k = 0; k < pad; k++) body.push_back(8'($urandom_range(0, 255)));
         end
      end
      for (int k = $urandom_range(0, 3); k > 0; k--) body.push_back(8'($urandom_range(0, 255)));
      for (int i = 0; i < body.size() && i < cut; i++)
         byte_plan.push_back('{value: body[i], opens_file: (i == 0)});
   endtask

   task automatic plan_random_files(input int unsigned goal);
      int unsigned w;
      int unsigned h;
      int unsigned off;
      int unsigned bpp;
      int unsigned cut;
      while (byte_plan.size() < goal) begin
         w   = $urandom_range(1, 6);
         h   = $urandom_range(1, 4);
         off = ($urandom_range(0, 3) == 0) ? $urandom_range(31, 45) : $urandom_range(0, 30);
         bpp = ($urandom_range(0, 3) != 0) ? 24 : $urandom_range(0, 16'hFFFF);
         cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 80) : NO_CUT;
         case ($urandom_range(0, 19))
            0: w = 0;
            1: h = 0;
            2: w = $urandom_range(DIM_LIMIT + 1, 32'hFFFF_FFFF);
            3: h = $urandom_range(DIM_LIMIT + 1, 32'hFFFF_FFFF);
            4, 5: begin
               w = $urandom_range(7, 64);
               h = $urandom_range(1, 3);
            end
            default: ;
         endcase
         plan_file(w, h, off, bpp, cut);
      end
   endtask

   // ------------------------------------------------------------------------
   // Sender: present planned bytes in bursts, predict each accepted byte
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         burst_left    <= 1;
         gap_left      <= 0;
      end else if (!req_bus.valid || req_bus.ready) begin
         if (req_bus.valid) begin
            decode_byte(req_bus.file_byte, req_bus.first_byte);
            void'(byte_plan.pop_front());
         end
         if (gap_left != 0 || byte_plan.size() == 0) begin
            req_bus.valid <= 1'b0;
            if (gap_left != 0) gap_left <= gap_left - 1;
         end else begin
            req_bus.valid      <= 1'b1;
            req_bus.file_byte  <= byte_plan[0].value;
            req_bus.first_byte <= byte_plan[0].opens_file;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 48);
               gap_left   <= ($urandom_range(0, 2) == 0) ? $urandom_range(1, 8) : 0;
            end else begin
               burst_left <= burst_left - 1;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Receiver: stall by mode, with one long hold-off to back up the input
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         hold_left     <= 0;
         mode_left     <= 0;
         stall_mode    <= 0;
         holdoff_done  <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_bus.ready <= 1'b0;
         hold_left     <= hold_left - 1;
      end else if (!holdoff_done && cycle_count >= HOLDOFF_AT) begin
         rsp_bus.ready <= 1'b0;
         hold_left     <= HOLDOFF_LEN;
         holdoff_done  <= 1'b1;
      end else begin
         if (mode_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            mode_left  <= $urandom_range(32, 200);
         end else begin
            mode_left <= mode_left - 1;
         end
         case (stall_mode)
            0:       rsp_bus.ready <= 1'b1;
            1:       rsp_bus.ready <= ($urandom_range(0, 3) != 0);
            2:       rsp_bus.ready <= STALL_PATTERN[cycle_count % 8];
            default: rsp_bus.ready <= ($urandom_range(0, 4) == 0);
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: compare each accepted pixel word with the oldest prediction
   // ------------------------------------------------------------------------
   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_pixels.size() == 0) begin
            $error("pixel word with none expected: index %0d", rsp_bus.pixel_index);
            mismatch_count++;
         end else begin
            oldest_pixel = pending_pixels.pop_front();
            check_field("pixel_index", oldest_pixel.pixel_index, rsp_bus.pixel_index);
            check_field("red", oldest_pixel.red, rsp_bus.red);
            check_field("green", oldest_pixel.green, rsp_bus.green);
            check_field("blue", oldest_pixel.blue, rsp_bus.blue);
            check_field("alpha", oldest_pixel.alpha, rsp_bus.alpha);
            check_field("last_pixel", oldest_pixel.last_pixel, rsp_bus.last_pixel);
            check_field("header_error", oldest_pixel.header_error, rsp_bus.header_error);
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("bmp_stream_pixel_decoder_core: mismatch");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus plan, reset and end of run
   // ------------------------------------------------------------------------
   initial begin
      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.file_byte  = '0;
      req_bus.first_byte = 1'b0;
      rsp_bus.ready      = 1'b0;
      clear_decoder();

      // Stray bytes before any file are dropped
      repeat (3) byte_plan.push_back('{value: 8'($urandom_range(0, 255)), opens_file: 1'b0});
      // Bad headers: zero width, too wide, zero height, top-down, high bits set
      plan_file(0, 1, 0, 24, NO_CUT);
      plan_file(DIM_LIMIT + 1, DIM_LIMIT, 0, 24, NO_CUT);
      plan_file(1, 0, 0, 24, NO_CUT);
      plan_file(2, 32'hFFFF_FFFF, 0, 24, NO_CUT);
      plan_file(32'h0001_0001, 1, 0, 24, NO_CUT);
      // Small images with each nonzero padding amount and skip lengths
      plan_file(1, 1, 0, 24, NO_CUT);
      plan_file(3, 2, 31, 24, NO_CUT);
      plan_file(2, 2, 34, 24, NO_CUT);
      plan_file(1, 3, PIXEL_START, 16'hFFFF, NO_CUT);
      // Largest valid sizes and an endless skip, cut by restarts; then 32 bpp
      plan_file(DIM_LIMIT, DIM_LIMIT, 0, 24, 150);
      plan_file(5, 1, 32'hFFFF_FFFF, 24, 45);
      plan_file(DIM_LIMIT, 1, 0, 8, 90);
      plan_file(4, 2, 0, 32, NO_CUT);
      // Fill with random files up to the planned stream length
      plan_random_files(PLAN_BYTES);

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      while (byte_plan.size() != 0 || pending_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("bmp_stream_pixel_decoder_core: match");
      else
         $display("bmp_stream_pixel_decoder_core: mismatch");
      $finish;
   end

endmodule
